[hdl/cst_pkg.sv]
package cst_pkg;

  // Sizes
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LINE_LIMIT = 4095;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Characters the scanner looks at
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;

  // Scanner mode, one-hot
  typedef enum logic [6:0] {
    M_PLAIN      = 7'b0000001,
    M_SLASH      = 7'b0000010,
    M_LINE_CMT   = 7'b0000100,
    M_BLOCK      = 7'b0001000,
    M_BLOCK_STAR = 7'b0010000,
    M_STRING     = 7'b0100000,
    M_CHAR       = 7'b1000000
  } mode_e;

  // Results caused by one request: up to two bytes, b0 first
  typedef struct packed {
    logic [1:0]        cnt;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b0;
  } res_t;

  // One queued result
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } entry_t;

endpackage

[hdl/cst_if.sv]
interface cst_in_if;
  logic                        valid;
  logic                        ready;
  logic [cst_pkg::BYTE_W-1:0]  in_byte;
  logic                        end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface cst_out_if;
  logic                        valid;
  logic                        ready;
  logic [cst_pkg::BYTE_W-1:0]  out_byte;
  logic                        last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

[hdl/cst_scan.sv]
module cst_scan #(
  parameter int unsigned LineLimit = cst_pkg::LINE_LIMIT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [cst_pkg::BYTE_W-1:0] byte_i,
  input  logic                       eot_i,
  output cst_pkg::res_t              res_o
);

  localparam int unsigned LenW = $clog2(LineLimit);

  cst_pkg::mode_e              mode_q, mode_d;
  logic [cst_pkg::BYTE_W-1:0]  prev_q;
  logic [LenW-1:0]             len_q;
  logic [LenW:0]               len_inc;
  logic                        at_end;
  logic                        plain;
  logic                        emit_slash;   // held slash released by a non-comment byte
  logic                        emit_byte;    // the byte itself
  logic                        emit_tail;    // slash still held at line end
  cst_pkg::mode_e              mode_mid;
  cst_pkg::res_t               res;

  assign len_inc = {1'b0, len_q} + (LenW+1)'(1);
  assign at_end  = (byte_i == cst_pkg::CH_NL) || (len_inc >= (LenW+1)'(LineLimit)) || eot_i;

  // Mode update and emitted bytes
  always_comb begin
    mode_mid   = mode_q;
    plain      = 1'b0;
    emit_slash = 1'b0;
    emit_byte  = 1'b0;
    unique case (mode_q)
      cst_pkg::M_SLASH: begin
        if (byte_i == cst_pkg::CH_SLASH) begin
          mode_mid = cst_pkg::M_LINE_CMT;
        end else if (byte_i == cst_pkg::CH_STAR) begin
          mode_mid = cst_pkg::M_BLOCK;
        end else begin
          emit_slash = 1'b1;
          plain      = 1'b1;
        end
      end
      cst_pkg::M_STRING, cst_pkg::M_CHAR: begin
        emit_byte = 1'b1;
        if ((byte_i == ((mode_q == cst_pkg::M_STRING) ? cst_pkg::CH_DQUOTE
                                                      : cst_pkg::CH_SQUOTE)) &&
            (prev_q != cst_pkg::CH_BSLASH)) begin
          mode_mid = cst_pkg::M_PLAIN;
        end
      end
      cst_pkg::M_LINE_CMT: begin
        mode_mid = cst_pkg::M_LINE_CMT;
      end
      cst_pkg::M_BLOCK: begin
        if (byte_i == cst_pkg::CH_NL) begin
          emit_byte = 1'b1;
        end else if (byte_i == cst_pkg::CH_STAR) begin
          mode_mid = cst_pkg::M_BLOCK_STAR;
        end
      end
      cst_pkg::M_BLOCK_STAR: begin
        if (byte_i == cst_pkg::CH_SLASH) begin
          mode_mid = cst_pkg::M_PLAIN;
        end else if (byte_i != cst_pkg::CH_STAR) begin
          mode_mid  = cst_pkg::M_BLOCK;
          emit_byte = (byte_i == cst_pkg::CH_NL);
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase

    // plain-text handling of the current byte
    if (plain) begin
      if (byte_i == cst_pkg::CH_DQUOTE) begin
        emit_byte = 1'b1;
        mode_mid  = cst_pkg::M_STRING;
      end else if (byte_i == cst_pkg::CH_SQUOTE) begin
        emit_byte = 1'b1;
        mode_mid  = cst_pkg::M_CHAR;
      end else if (byte_i == cst_pkg::CH_SLASH) begin
        mode_mid  = cst_pkg::M_SLASH;
      end else begin
        emit_byte = 1'b1;
        mode_mid  = cst_pkg::M_PLAIN;
      end
    end

    emit_tail = at_end && (mode_mid == cst_pkg::M_SLASH);
    mode_d    = at_end ? cst_pkg::M_PLAIN : mode_mid;
  end

  // Pack emitted bytes in order; never more than two
  always_comb begin
    res = '0;
    if (emit_slash) begin
      res.b0  = cst_pkg::CH_SLASH;
      res.cnt = 2'd1;
    end
    if (emit_byte) begin
      if (res.cnt == 2'd0) begin
        res.b0 = byte_i;
      end else begin
        res.b1 = byte_i;
      end
      res.cnt = res.cnt + 2'd1;
    end
    if (emit_tail) begin
      if (res.cnt == 2'd0) begin
        res.b0 = cst_pkg::CH_SLASH;
      end else begin
        res.b1 = cst_pkg::CH_SLASH;
      end
      res.cnt = res.cnt + 2'd1;
    end
  end

  assign res_o = res;

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cst_pkg::M_PLAIN;
      prev_q <= '0;
      len_q  <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      if (at_end) begin
        prev_q <= '0;
        len_q  <= '0;
      end else begin
        prev_q <= byte_i;
        len_q  <= len_inc[LenW-1:0];
      end
    end
  end

  // A line end always leaves the scanner in plain text with a fresh line
  a_line_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && at_end |=> (mode_q == cst_pkg::M_PLAIN) && (len_q == '0) && (prev_q == '0))
    else $error("scanner state not cleared at line end");

  // Line length stays below the limit
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, len_q} < (LenW+1)'(LineLimit)))
    else $error("line length reached the limit");

  // At most two results per request
  a_res_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> (res.cnt != 2'd3))
    else $error("more than two results for one byte");

endmodule

[hdl/cst_fifo.sv]
module cst_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cst_pkg::res_t  push_res_i,
  input  logic           pop_i,
  output logic           space_o,
  output logic           valid_o,
  output cst_pkg::entry_t entry_o
);

  localparam int unsigned Depth = cst_pkg::FIFO_DEPTH;
  localparam int unsigned PtrW  = cst_pkg::PTR_W;
  localparam int unsigned CntW  = cst_pkg::CNT_W;

  cst_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      push_n;
  logic            pop;

  assign push_n  = push_i ? push_res_i.cnt : 2'd0;
  assign pop     = pop_i && valid_o;
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];
  // room for the largest burst of one request
  assign space_o = (cnt_q <= CntW'(Depth - 2));
  assign cnt_d   = cnt_q + CntW'(push_n) - CntW'(pop);

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_q] <= '{data: push_res_i.b0, last: (push_n == 2'd1)};
    end
    if (push_n == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= '{data: push_res_i.b1, last: 1'b1};
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_n);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0) |-> space_o)
    else $error("push without room");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) || (cnt_q == CntW'(Depth)) || (wr_q != rd_q))
    else $error("pointers disagree with fill count");

endmodule

[hdl/comment_stripping_text_filter_top.sv]
// Channel   Dir  Payload                    Transfer
// in_i      in   in_byte[7:0], end_of_text  valid && ready
// out_o     out  out_byte[7:0], last_of_run valid && ready
//
// One text byte is taken per cycle while ready is high; its 0 to 2 result
// bytes go into a four-entry result queue and leave one per out_o ready cycle.
// Input ready drops when the queue holds more than two entries, so a byte
// that yields two results slows the sustained input rate to the output rate.
// Reset (rst_ni, async, active low) clears the scanner to plain text and
// empties the queue; a stalled output only backs up through the queue.
module comment_stripping_text_filter_top #(
  parameter int unsigned LineLimit = cst_pkg::LINE_LIMIT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cst_in_if.sink    in_i,
  cst_out_if.source out_o
);

  logic            fire;
  logic            space;
  cst_pkg::res_t   res;
  cst_pkg::entry_t entry;

  assign in_i.ready = space;
  assign fire       = in_i.valid && space;

  // Per-byte scanner
  cst_scan #(
    .LineLimit (LineLimit)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_i.in_byte),
    .eot_i  (in_i.end_of_text),
    .res_o  (res)
  );

  // Result queue
  cst_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fire),
    .push_res_i (res),
    .pop_i      (out_o.ready),
    .space_o    (space),
    .valid_o    (out_o.valid),
    .entry_o    (entry)
  );

  assign out_o.out_byte    = entry.data;
  assign out_o.last_of_run = entry.last;

endmodule
